FILE: rtl/core/ssc_pkg.sv
// Shared types, constants and the commutation select table of the six-step controller.
package ssc_pkg;

  localparam int unsigned OpW     = 2;
  localparam int unsigned ThrW    = 12;
  localparam int unsigned DutyW   = 12;
  localparam int unsigned PeriodW = 16;
  localparam int unsigned StepW   = 3;
  localparam int unsigned SelW    = 2;
  localparam int unsigned AddrW   = 5;
  localparam int unsigned DataW   = 32;
  localparam int unsigned RegIdxW = 3;

  localparam logic [ThrW-1:0]    StartThresholdRst = 12'd1500;
  localparam logic [DutyW-1:0]   DutyStartRst      = 12'd151;
  localparam logic [DutyW-1:0]   DutyLimitRst      = 12'd400;
  localparam logic [PeriodW-1:0] PeriodStartRst    = 16'd3500;
  localparam logic [PeriodW-1:0] PeriodLimitRst    = 16'd1980;
  localparam logic [PeriodW-1:0] PeriodOffsetRst   = 16'd4050;
  localparam logic [DutyW-1:0]   AppliedDutyRst    = 12'd1000;
  localparam logic [PeriodW-1:0] AppliedPeriodRst  = 16'd48000;

  localparam logic [StepW-1:0] StepLast = 3'd5;
  localparam logic [SelW-1:0]  SelOff   = 2'd3;

  typedef enum logic [OpW-1:0] {
    OP_THROTTLE  = 2'd0,
    OP_RAMP      = 2'd1,
    OP_COMMUTATE = 2'd2,
    OP_NONE      = 2'd3
  } ssc_op_e;

  typedef enum logic [RegIdxW-1:0] {
    REG_START_THRESHOLD = 3'd0,
    REG_DUTY_START      = 3'd1,
    REG_DUTY_LIMIT      = 3'd2,
    REG_PERIOD_START    = 3'd3,
    REG_PERIOD_LIMIT    = 3'd4,
    REG_PERIOD_OFFSET   = 3'd5
  } ssc_reg_e;

  typedef struct packed {
    logic [ThrW-1:0]    start_threshold;
    logic [DutyW-1:0]   duty_start;
    logic [DutyW-1:0]   duty_limit;
    logic [PeriodW-1:0] period_start;
    logic [PeriodW-1:0] period_limit;
    logic [PeriodW-1:0] period_offset;
  } ssc_cfg_t;

  // Everything a result transaction reports.
  typedef struct packed {
    logic [SelW-1:0]    high_select;
    logic [SelW-1:0]    low_select;
    logic [DutyW-1:0]   pwm_compare;
    logic [PeriodW-1:0] commutation_period;
    logic [StepW-1:0]   step_index;
    logic               running;
    logic               throttle_mode;
  } ssc_result_t;

  // High/low select pair for a step; out-of-range steps switch everything off.
  function automatic logic [2*SelW-1:0] ssc_step_sel(input logic [StepW-1:0] step);
    logic [2*SelW-1:0] sel;
    unique case (step)
      3'd0:    sel = {2'd1, 2'd0};
      3'd1:    sel = {2'd2, 2'd0};
      3'd2:    sel = {2'd2, 2'd1};
      3'd3:    sel = {2'd0, 2'd1};
      3'd4:    sel = {2'd0, 2'd2};
      3'd5:    sel = {2'd1, 2'd2};
      default: sel = {SelOff, SelOff};
    endcase
    return sel;
  endfunction

endpackage

FILE: rtl/core/ssc_if.sv
// Valid/ready channel interfaces for event and result transactions.
interface ssc_in_if;
  logic                       valid;
  logic                       ready;
  logic [ssc_pkg::OpW-1:0]    operation;
  logic [ssc_pkg::ThrW-1:0]   throttle;

  modport source (output valid, operation, throttle, input ready);
  modport sink   (input valid, operation, throttle, output ready);
endinterface

interface ssc_out_if;
  logic                         valid;
  logic                         ready;
  logic [ssc_pkg::SelW-1:0]     high_select;
  logic [ssc_pkg::SelW-1:0]     low_select;
  logic [ssc_pkg::DutyW-1:0]    pwm_compare;
  logic [ssc_pkg::PeriodW-1:0]  commutation_period;
  logic [ssc_pkg::StepW-1:0]    step_index;
  logic                         running;
  logic                         throttle_mode;

  modport source (output valid, high_select, low_select, pwm_compare, commutation_period,
                  step_index, running, throttle_mode, input ready);
  modport sink   (input valid, high_select, low_select, pwm_compare, commutation_period,
                  step_index, running, throttle_mode, output ready);
endinterface

FILE: rtl/core/ssc_cfg_regs.sv
// APB register file holding thresholds and ramp limits.
module ssc_cfg_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ssc_pkg::AddrW-1:0]  paddr,
  input  logic [ssc_pkg::DataW-1:0]  pwdata,
  output logic [ssc_pkg::DataW-1:0]  prdata,
  output logic                       pready,
  output ssc_pkg::ssc_cfg_t          cfg_o
);
  import ssc_pkg::*;

  ssc_cfg_t         cfg_q, cfg_d;
  logic             wr_en;
  logic [RegIdxW-1:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[AddrW-1:2];

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_START_THRESHOLD: cfg_d.start_threshold = pwdata[ThrW-1:0];
        REG_DUTY_START:      cfg_d.duty_start      = pwdata[DutyW-1:0];
        REG_DUTY_LIMIT:      cfg_d.duty_limit      = pwdata[DutyW-1:0];
        REG_PERIOD_START:    cfg_d.period_start    = pwdata[PeriodW-1:0];
        REG_PERIOD_LIMIT:    cfg_d.period_limit    = pwdata[PeriodW-1:0];
        REG_PERIOD_OFFSET:   cfg_d.period_offset   = pwdata[PeriodW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_START_THRESHOLD: prdata = {{(DataW-ThrW){1'b0}}, cfg_q.start_threshold};
      REG_DUTY_START:      prdata = {{(DataW-DutyW){1'b0}}, cfg_q.duty_start};
      REG_DUTY_LIMIT:      prdata = {{(DataW-DutyW){1'b0}}, cfg_q.duty_limit};
      REG_PERIOD_START:    prdata = {{(DataW-PeriodW){1'b0}}, cfg_q.period_start};
      REG_PERIOD_LIMIT:    prdata = {{(DataW-PeriodW){1'b0}}, cfg_q.period_limit};
      REG_PERIOD_OFFSET:   prdata = {{(DataW-PeriodW){1'b0}}, cfg_q.period_offset};
      default:             prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_threshold <= StartThresholdRst;
      cfg_q.duty_start      <= DutyStartRst;
      cfg_q.duty_limit      <= DutyLimitRst;
      cfg_q.period_start    <= PeriodStartRst;
      cfg_q.period_limit    <= PeriodLimitRst;
      cfg_q.period_offset   <= PeriodOffsetRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: rtl/core/ssc_core.sv
// Controller state and its per-event update.
module ssc_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  ssc_pkg::ssc_cfg_t          cfg_i,
  input  logic                       exec_i,
  input  logic [ssc_pkg::OpW-1:0]    op_i,
  input  logic [ssc_pkg::ThrW-1:0]   thr_i,
  output ssc_pkg::ssc_result_t       state_o
);
  import ssc_pkg::*;

  logic               run_q, run_d;
  logic               mode_q, mode_d;
  logic [StepW-1:0]   step_q, step_d;
  logic [DutyW-1:0]   ramp_duty_q, ramp_duty_d;
  logic [PeriodW-1:0] ramp_period_q, ramp_period_d;
  logic [DutyW-1:0]   duty_q, duty_d;
  logic [PeriodW-1:0] period_q, period_d;
  logic [SelW-1:0]    hi_q, hi_d, lo_q, lo_d;

  logic below, above, duty_done, period_done;
  logic [2*SelW-1:0] sel;
  ssc_op_e op;

  assign op          = ssc_op_e'(op_i);
  assign below       = thr_i < cfg_i.start_threshold;
  assign above       = thr_i > cfg_i.start_threshold;
  assign duty_done   = !(ramp_duty_q < cfg_i.duty_limit);
  assign period_done = !(ramp_period_q > cfg_i.period_limit);
  assign sel         = ssc_step_sel(step_q);

  always_comb begin
    run_d         = run_q;
    mode_d        = mode_q;
    step_d        = step_q;
    ramp_duty_d   = ramp_duty_q;
    ramp_period_d = ramp_period_q;
    duty_d        = duty_q;
    period_d      = period_q;
    hi_d          = hi_q;
    lo_d          = lo_q;
    if (exec_i) begin
      unique case (op)
        OP_THROTTLE: begin
          if (below) begin
            mode_d        = 1'b0;
            ramp_duty_d   = cfg_i.duty_start;
            ramp_period_d = cfg_i.period_start;
            if (run_q) begin
              run_d  = 1'b0;
              hi_d   = SelOff;
              lo_d   = SelOff;
              step_d = '0;
            end
          end else begin
            if (!run_q) step_d = '0;
            run_d = 1'b1;
            // mode can only already be set when running
            if (mode_q && above) begin
              period_d = ({{(PeriodW-ThrW){1'b0}}, thr_i} < cfg_i.period_offset) ?
                         cfg_i.period_offset - {{(PeriodW-ThrW){1'b0}}, thr_i} : '0;
            end
          end
        end
        OP_RAMP: begin
          if (run_q && !mode_q) begin
            duty_d   = ramp_duty_q;
            period_d = ramp_period_q;
            if (!duty_done)   ramp_duty_d   = ramp_duty_q + 1'b1;
            if (!period_done) ramp_period_d = ramp_period_q - 1'b1;
            if (duty_done && period_done) mode_d = 1'b1;
          end
        end
        OP_COMMUTATE: begin
          if (run_q) begin
            {hi_d, lo_d} = sel;
            step_d = (step_q < StepLast) ? step_q + 1'b1 : '0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q         <= 1'b0;
      mode_q        <= 1'b0;
      step_q        <= '0;
      ramp_duty_q   <= DutyStartRst;
      ramp_period_q <= PeriodStartRst;
      duty_q        <= AppliedDutyRst;
      period_q      <= AppliedPeriodRst;
      hi_q          <= '0;
      lo_q          <= '0;
    end else begin
      run_q         <= run_d;
      mode_q        <= mode_d;
      step_q        <= step_d;
      ramp_duty_q   <= ramp_duty_d;
      ramp_period_q <= ramp_period_d;
      duty_q        <= duty_d;
      period_q      <= period_d;
      hi_q          <= hi_d;
      lo_q          <= lo_d;
    end
  end

  // state after this event, captured into the result register
  assign state_o = '{high_select: hi_d, low_select: lo_d, pwm_compare: duty_d,
                     commutation_period: period_d, step_index: step_d,
                     running: run_d, throttle_mode: mode_d};

`ifndef SYNTHESIS
  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q <= StepLast) else $error("step index out of range");

  a_mode_needs_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q |-> run_q) else $error("throttle mode without run");

  a_ramp_applies: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec_i && op_i == OP_RAMP && run_q && !mode_q |=> duty_q == $past(ramp_duty_q)
      && period_q == $past(ramp_period_q)) else $error("ramp values not applied");
`endif

endmodule

FILE: rtl/core/six_step_commutation_startup.sv
// Top level of the six-step commutation controller with open-loop startup ramp.
// One event (throttle sample, ramp tick or commutation tick) per transaction on
// item_i yields exactly one result transaction on result_o reporting the state
// after the event. Events pass an input register, the state update (compares, one
// increment/decrement, a six-entry select table) and a result register, so one
// event is accepted every cycle while no finished result is held back by ready; each
// result is presented from the result register until it is taken. While a finished result
// waits for ready, the input register can take one more event and then holds
// item_i.ready low until the result goes. Thresholds and ramp limits sit in APB
// registers at byte addresses 0x00..0x14; write them only while no event is in flight.
module six_step_commutation_startup (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ssc_pkg::AddrW-1:0]  paddr,
  input  logic [ssc_pkg::DataW-1:0]  pwdata,
  output logic [ssc_pkg::DataW-1:0]  prdata,
  output logic                       pready,
  ssc_in_if.sink                     item_i,
  ssc_out_if.source                  result_o
);
  import ssc_pkg::*;

  ssc_cfg_t        cfg;
  ssc_result_t     state_nxt;

  // input register
  logic            in_vld_q, in_vld_d;
  logic [OpW-1:0]  in_op_q;
  logic [ThrW-1:0] in_thr_q;
  // result register
  logic            out_vld_q, out_vld_d;
  ssc_result_t     res_q;

  logic adv, exec, in_take;

  assign adv     = !out_vld_q || result_o.ready;   // result slot free this cycle
  assign exec    = in_vld_q && adv;                 // event updates state now
  assign item_i.ready = !in_vld_q || adv;
  assign in_take = item_i.valid && item_i.ready;

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_take)   in_vld_d = 1'b1;
    else if (exec) in_vld_d = 1'b0;
    out_vld_d = out_vld_q;
    if (exec)                 out_vld_d = 1'b1;
    else if (result_o.ready)  out_vld_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_op_q  <= item_i.operation;
      in_thr_q <= item_i.throttle;
    end
    if (exec) res_q <= state_nxt;
  end

  ssc_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  ssc_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .exec_i  (exec),
    .op_i    (in_op_q),
    .thr_i   (in_thr_q),
    .state_o (state_nxt)
  );

  assign result_o.valid              = out_vld_q;
  assign result_o.high_select        = res_q.high_select;
  assign result_o.low_select         = res_q.low_select;
  assign result_o.pwm_compare        = res_q.pwm_compare;
  assign result_o.commutation_period = res_q.commutation_period;
  assign result_o.step_index         = res_q.step_index;
  assign result_o.running            = res_q.running;
  assign result_o.throttle_mode      = res_q.throttle_mode;

`ifndef SYNTHESIS
  a_result_from_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(in_vld_q)) else $error("result without event");

  a_stall_holds_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && !adv |=> in_vld_q && $stable(in_op_q) && $stable(in_thr_q))
    else $error("stalled event lost");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !result_o.ready |=> out_vld_q && $stable(res_q))
    else $error("pending result overwritten");
`endif

endmodule

FILE: bench/tb_top.sv
// Self-checking bench for the six-step commutation controller with open-loop startup ramp.
`timescale 1ns / 1ps

module tb_top;
  import ssc_pkg::*;

  // Cycles with neither an event nor a result transaction before the run is abandoned.
  // The slowest correct gap is a long receiver stall at 45 % idling plus a drain.
  localparam int unsigned StallLimit = 2000;
  // Cycles allowed after the last result for anything late to show up.
  localparam int unsigned TailCycles = 8;

  // Predicts the controller state after each event and keeps the results still owed.
  class commutation_scoreboard;
    ssc_cfg_t         cfg;
    logic             run;
    logic             mode;
    logic [StepW-1:0]   step;
    logic [DutyW-1:0]   ramp_duty;
    logic [PeriodW-1:0] ramp_period;
    logic [DutyW-1:0]   duty_now;
    logic [PeriodW-1:0] period_now;
    logic [SelW-1:0]    sel_hi;
    logic [SelW-1:0]    sel_lo;
    ssc_result_t        owed_q[$];
    int unsigned        errors;

    function new();
      cfg.start_threshold = StartThresholdRst;
      cfg.duty_start      = DutyStartRst;
      cfg.duty_limit      = DutyLimitRst;
      cfg.period_start    = PeriodStartRst;
      cfg.period_limit    = PeriodLimitRst;
      cfg.period_offset   = PeriodOffsetRst;
      run         = 1'b0;
      mode        = 1'b0;
      step        = '0;
      ramp_duty   = DutyStartRst;
      ramp_period = PeriodStartRst;
      duty_now    = AppliedDutyRst;
      period_now  = AppliedPeriodRst;
      sel_hi      = '0;
      sel_lo      = '0;
      errors      = 0;
    endfunction

    function int unsigned pending();
      return owed_q.size();
    endfunction

    // Register write; values are cut to the register width, unknown indexes dropped.
    function void write_reg(logic [RegIdxW-1:0] idx, logic [DataW-1:0] value);
      case (idx)
        REG_START_THRESHOLD: cfg.start_threshold = value[ThrW-1:0];
        REG_DUTY_START:      cfg.duty_start      = value[DutyW-1:0];
        REG_DUTY_LIMIT:      cfg.duty_limit      = value[DutyW-1:0];
        REG_PERIOD_START:    cfg.period_start    = value[PeriodW-1:0];
        REG_PERIOD_LIMIT:    cfg.period_limit    = value[PeriodW-1:0];
        REG_PERIOD_OFFSET:   cfg.period_offset   = value[PeriodW-1:0];
        default: ;
      endcase
    endfunction

    function logic [DataW-1:0] reg_value(logic [RegIdxW-1:0] idx);
      case (idx)
        REG_START_THRESHOLD: return DataW'(cfg.start_threshold);
        REG_DUTY_START:      return DataW'(cfg.duty_start);
        REG_DUTY_LIMIT:      return DataW'(cfg.duty_limit);
        REG_PERIOD_START:    return DataW'(cfg.period_start);
        REG_PERIOD_LIMIT:    return DataW'(cfg.period_limit);
        REG_PERIOD_OFFSET:   return DataW'(cfg.period_offset);
        default:             return '0;
      endcase
    endfunction

    // One accepted event: advance the state and owe one result.
    function void note_event(logic [OpW-1:0] op, logic [ThrW-1:0] thr);
      logic        duty_done;
      logic        period_done;
      ssc_result_t res;
      case (op)
        OP_THROTTLE: begin
          if (thr < cfg.start_threshold) begin
            // stop: selects only switch off if the motor was turning
            mode = 1'b0;
            if (run) begin
              run    = 1'b0;
              sel_hi = SelOff;
              sel_lo = SelOff;
              step   = '0;
            end
            ramp_duty   = cfg.duty_start;
            ramp_period = cfg.period_start;
          end else begin
            if (!run) step = '0;
            run = 1'b1;
          end
          // equal to threshold leaves the period alone; past the offset it pins at 0
          if (run && mode && thr > cfg.start_threshold)
            period_now = (PeriodW'(thr) < cfg.period_offset) ?
                         cfg.period_offset - PeriodW'(thr) : '0;
        end
        OP_RAMP: begin
          if (run && !mode) begin
            duty_now    = ramp_duty;
            period_now  = ramp_period;
            duty_done   = !(ramp_duty < cfg.duty_limit);
            if (!duty_done) ramp_duty = ramp_duty + 1'b1;
            period_done = !(ramp_period > cfg.period_limit);
            if (!period_done) ramp_period = ramp_period - 1'b1;
            if (duty_done && period_done) mode = 1'b1;
          end
        end
        OP_COMMUTATE: begin
          if (run) begin
            case (step)
              3'd0:    begin sel_hi = 2'd1; sel_lo = 2'd0; end
              3'd1:    begin sel_hi = 2'd2; sel_lo = 2'd0; end
              3'd2:    begin sel_hi = 2'd2; sel_lo = 2'd1; end
              3'd3:    begin sel_hi = 2'd0; sel_lo = 2'd1; end
              3'd4:    begin sel_hi = 2'd0; sel_lo = 2'd2; end
              3'd5:    begin sel_hi = 2'd1; sel_lo = 2'd2; end
              default: begin sel_hi = SelOff; sel_lo = SelOff; end
            endcase
            step = (step < StepLast) ? step + 1'b1 : '0;
          end
        end
        default: ;
      endcase
      res.high_select        = sel_hi;
      res.low_select         = sel_lo;
      res.pwm_compare        = duty_now;
      res.commutation_period = period_now;
      res.step_index         = step;
      res.running            = run;
      res.throttle_mode      = mode;
      owed_q.push_back(res);
    endfunction

    task flag(string msg);
      $display("ERROR @%0t: %s", $realtime, msg);
      errors++;
    endtask

    task compare_field(string name, logic [15:0] got, logic [15:0] want);
      if (got !== want) flag($sformatf("%s got %0d, expected %0d", name, got, want));
    endtask

    task check_result(ssc_result_t got);
      ssc_result_t want;
      if (owed_q.size() == 0) begin
        flag("result transaction with no event waiting");
      end else begin
        want = owed_q.pop_front();
        compare_field("high_select",        16'(got.high_select),  16'(want.high_select));
        compare_field("low_select",         16'(got.low_select),   16'(want.low_select));
        compare_field("pwm_compare",        16'(got.pwm_compare),  16'(want.pwm_compare));
        compare_field("commutation_period", got.commutation_period,
                      want.commutation_period);
        compare_field("step_index",         16'(got.step_index),   16'(want.step_index));
        compare_field("running",            16'(got.running),      16'(want.running));
        compare_field("throttle_mode",      16'(got.throttle_mode), 16'(want.throttle_mode));
      end
    endtask
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [AddrW-1:0]   paddr;
  logic [DataW-1:0]   pwdata;
  logic [DataW-1:0]   prdata;
  logic               pready;

  ssc_in_if  item_if ();
  ssc_out_if res_if ();

  six_step_commutation_startup dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .item_i   (item_if),
    .result_o (res_if)
  );

  commutation_scoreboard sb;
  int unsigned snd_idle_pct;  // chance per cycle that the event source holds back
  int unsigned rcv_idle_pct;  // chance per cycle that the result sink drops ready
  int unsigned quiet_cycles;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Result sink: ready changes on the falling edge only.
  initial begin
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      res_if.ready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  // Every result transaction is checked against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid === 1'b1 && res_if.ready === 1'b1)
      sb.check_result('{res_if.high_select, res_if.low_select, res_if.pwm_compare,
                        res_if.commutation_period, res_if.step_index, res_if.running,
                        res_if.throttle_mode});
  end

  // Watchdog: any transaction on either channel restarts the count.
  initial quiet_cycles = 0;
  always @(posedge clk_i) begin
    if ((item_if.valid === 1'b1 && item_if.ready === 1'b1) ||
        (res_if.valid === 1'b1 && res_if.ready === 1'b1)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offers one event, idling first at the source's rate; entered and left on a
  // falling edge. valid is left high so the next event can follow back to back.
  task automatic send_event(input logic [OpW-1:0] op, input logic [ThrW-1:0] thr);
    while ($urandom_range(99) < snd_idle_pct) begin
      item_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    item_if.valid     <= 1'b1;
    item_if.operation <= op;
    item_if.throttle  <= thr;
    do @(posedge clk_i); while (item_if.ready !== 1'b1);
    sb.note_event(op, thr);
    @(negedge clk_i);
  endtask

  // Drops valid and holds off until every owed result is in; the block is then
  // idle, since each event yields exactly one result.
  task automatic settle();
    item_if.valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // APB write, then a back-to-back read of the same register for known indexes.
  task automatic apb_write(input logic [RegIdxW-1:0] idx, input logic [DataW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    sb.write_reg(idx, value);
    @(negedge clk_i);
    if (idx <= REG_PERIOD_OFFSET) begin
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clk_i);
      penable <= 1'b1;
      do @(posedge clk_i); while (pready !== 1'b1);
      if (prdata !== sb.reg_value(idx))
        sb.flag($sformatf("register %0d reads %0h, expected %0h", idx, prdata,
                          sb.reg_value(idx)));
      @(negedge clk_i);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic write_all(input logic [DataW-1:0] thr_lvl, input logic [DataW-1:0] d_start,
                           input logic [DataW-1:0] d_lim, input logic [DataW-1:0] p_start,
                           input logic [DataW-1:0] p_lim, input logic [DataW-1:0] p_off);
    apb_write(REG_START_THRESHOLD, thr_lvl);
    apb_write(REG_DUTY_START,      d_start);
    apb_write(REG_DUTY_LIMIT,      d_lim);
    apb_write(REG_PERIOD_START,    p_start);
    apb_write(REG_PERIOD_LIMIT,    p_lim);
    apb_write(REG_PERIOD_OFFSET,   p_off);
  endtask

  // Random setting with short ramps so throttle mode is reached often. Upper
  // bits of every write are junk that the register must drop.
  task automatic random_short_ramps();
    logic [DutyW-1:0]   d0;
    logic [PeriodW-1:0] p_lim;
    d0    = $urandom_range(4095);
    p_lim = $urandom_range(65535);
    write_all($urandom,
              ($urandom & 32'hFFFF_F000) | d0,
              ($urandom & 32'hFFFF_F000) | DutyW'(d0 + $urandom_range(12)),
              ($urandom & 32'hFFFF_0000) | PeriodW'(p_lim + $urandom_range(12)),
              ($urandom & 32'hFFFF_0000) | p_lim,
              $urandom);
  endtask

  // Throttle value for a motor meant to keep running: mostly at or above the
  // start level, with the level itself and the saturation point hit often.
  function automatic logic [ThrW-1:0] run_throttle();
    logic [ThrW-1:0]    lvl;
    logic [PeriodW-1:0] off;
    lvl = sb.cfg.start_threshold;
    off = sb.cfg.period_offset;
    case ($urandom_range(7))
      0:       return lvl;
      1:       return ThrW'($urandom_range(4095));
      2:       return (off > 1 && off < 4094) ? ThrW'(off - 1 + $urandom_range(2)) : lvl;
      default: return ThrW'($urandom_range(4095, lvl));
    endcase
  endfunction

  function automatic logic [ThrW-1:0] stop_throttle();
    logic [ThrW-1:0] lvl;
    lvl = sb.cfg.start_threshold;
    if (lvl == 0) return '0;  // nothing stops the motor at a zero threshold
    return ($urandom_range(1) == 0) ? lvl - 1'b1 : ThrW'($urandom_range(lvl - 1));
  endfunction

  // Mostly a running motor with random ticks; noise and stops for the rest.
  task automatic random_events(input int unsigned count);
    int unsigned r;
    repeat (count) begin
      r = $urandom_range(99);
      if (r < 12)      send_event(OpW'($urandom_range(3)), ThrW'($urandom_range(4095)));
      else if (r < 18) send_event(OP_THROTTLE, stop_throttle());
      else if (r < 38) send_event(OP_THROTTLE, run_throttle());
      else if (r < 68) send_event(OP_RAMP, ThrW'($urandom_range(4095)));
      else             send_event(OP_COMMUTATE, ThrW'($urandom_range(4095)));
      // occasionally hold the source until the sink has caught up
      if ($urandom_range(99) < 2) settle();
    end
  endtask

  initial begin
    rst_ni            = 1'b0;
    item_if.valid     = 1'b0;
    item_if.operation = OP_THROTTLE;
    item_if.throttle  = '0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    snd_idle_pct      = 23;
    rcv_idle_pct      = 45;
    sb                = new();
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset values: ticks while stopped, the idle code, stops while stopped,
    // start exactly at the threshold, a full step cycle with wrap, then a stop.
    send_event(OP_RAMP,      12'hFFF);
    send_event(OP_COMMUTATE, 12'h000);
    send_event(OP_NONE,      12'hA5A);
    send_event(OP_THROTTLE,  12'd0);
    send_event(OP_THROTTLE,  StartThresholdRst - 1'b1);
    send_event(OP_THROTTLE,  StartThresholdRst);
    repeat (6) send_event(OP_COMMUTATE, ThrW'($urandom_range(4095)));
    send_event(OP_RAMP,      12'h5A5);
    send_event(OP_THROTTLE,  12'hFFF);
    send_event(OP_THROTTLE,  12'd0);
    send_event(OP_NONE,      12'hFFF);
    random_events(100);

    // Two-tick ramps: reach throttle mode, then the level itself, saturation
    // past the offset, an ordinary subtraction and full scale.
    settle();
    write_all(2000, 99, 100, 501, 500, 3000);
    send_event(OP_THROTTLE, 12'd0);
    send_event(OP_THROTTLE, 12'd2000);
    repeat (3) send_event(OP_RAMP, 12'd0);
    send_event(OP_THROTTLE, 12'd2000);
    send_event(OP_THROTTLE, 12'd3500);
    send_event(OP_THROTTLE, 12'd2500);
    send_event(OP_THROTTLE, 12'hFFF);
    random_events(100);

    snd_idle_pct = 45;
    rcv_idle_pct = 23;
    // All registers at zero: the motor never stops and the period pins at 0.
    settle();
    write_all(0, 0, 0, 0, 0, 0);
    random_events(100);

    // All ones, masked to full scale; writes beyond the last register are dropped.
    settle();
    write_all('1, '1, '1, '1, '1, '1);
    apb_write(3'd6, $urandom);
    apb_write(3'd7, $urandom);
    random_events(100);

    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    settle();
    random_short_ramps();
    random_events(100);

    settle();
    random_short_ramps();
    random_events(100);

    settle();
    repeat (TailCycles) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
